// ===== rtl/core/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

    localparam int DQ_DEPTH   = 32;
    localparam int IDX_W      = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;
    localparam int CNT_W      = $clog2(DQ_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 3;
    localparam int STAT_W     = 2;
    localparam int IN_TDATA_W = ((KIND_W + DATA_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR,
        OP_DUMP_START,
        OP_REPLY,
        OP_POP_OUT,
        OP_DUMP_OUT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic dump_last;
    } t_dp_stat;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DQ_DEPTH - 1)) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DQ_DEPTH - 1) : IDX_W'(idx - 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(cnt);
        if (sum >= (CNT_W + 1)'(DQ_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DQ_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dq_ram.sv =====
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  wire logic [WIDTH-1:0]                 i_wr_data,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic      [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dq_dp.sv =====
`default_nettype none

module dq_dp
    import dq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [DATA_W-1:0] i_value,
    output t_dp_stat               o_stat,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic      [DATA_W-1:0] o_out_data,
    output t_status                o_out_status,
    output logic                   o_out_last
);

    logic [IDX_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_occ, n_occ;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    t_status           r_out_status;
    logic              r_out_last;

    logic              we, re, load, ld_last;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] rd_data, ld_data;
    t_status           ld_status;

    dq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DQ_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_value),
        .i_re     (re),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_front   = r_front;
        n_occ     = r_occ;
        n_ptr     = r_ptr;
        n_rem     = r_rem;
        we        = 1'b0;
        wr_addr   = r_front;
        re        = 1'b0;
        rd_addr   = r_front;
        load      = 1'b0;
        ld_data   = '0;
        ld_status = ST_OK;
        ld_last   = 1'b1;
        case (i_cmd.op)
            OP_PUSH_FRONT: begin
                n_front = ring_dec(r_front);
                we      = 1'b1;
                wr_addr = ring_dec(r_front);
                n_occ   = CNT_W'(r_occ + 1'b1);
                load    = 1'b1;
            end
            OP_PUSH_REAR: begin
                we      = 1'b1;
                wr_addr = ring_add(r_front, r_occ);
                n_occ   = CNT_W'(r_occ + 1'b1);
                load    = 1'b1;
            end
            OP_POP_FRONT: begin
                re      = 1'b1;
                rd_addr = r_front;
                n_front = ring_inc(r_front);
                n_occ   = CNT_W'(r_occ - 1'b1);
            end
            OP_POP_REAR: begin
                re      = 1'b1;
                rd_addr = ring_add(r_front, CNT_W'(r_occ - 1'b1));
                n_occ   = CNT_W'(r_occ - 1'b1);
            end
            OP_DUMP_START: begin
                re      = 1'b1;
                rd_addr = r_front;
                n_ptr   = ring_inc(r_front);
                n_rem   = CNT_W'(r_occ - 1'b1);
            end
            OP_REPLY: begin
                load      = 1'b1;
                ld_status = i_cmd.status;
            end
            OP_POP_OUT: begin
                load    = 1'b1;
                ld_data = rd_data;
            end
            OP_DUMP_OUT: begin
                load    = 1'b1;
                ld_data = rd_data;
                ld_last = (r_rem == '0);
                if (r_rem != '0) begin
                    re      = 1'b1;
                    rd_addr = r_ptr;
                    n_ptr   = ring_inc(r_ptr);
                    n_rem   = CNT_W'(r_rem - 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_occ   <= n_occ;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_rem <= n_rem;
        if (load) begin
            r_out_data   <= ld_data;
            r_out_status <= ld_status;
            r_out_last   <= ld_last;
        end
    end

    assign o_stat.empty     = (r_occ == '0);
    assign o_stat.full      = (r_occ == CNT_W'(DQ_DEPTH));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.dump_last = (r_rem == '0);

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/dq_ctrl.sv =====
`default_nettype none

module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [KIND_W-1:0] i_kind,
    output logic                   o_ready,
    input  wire t_dp_stat          i_stat,
    output t_cmd                   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_DUMP_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                            if (i_stat.full) begin
                                o_cmd.op     = OP_REPLY;
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.op = (i_kind == KIND_PUSH_FRONT) ?
                                           OP_PUSH_FRONT : OP_PUSH_REAR;
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_REAR: begin
                            if (i_stat.empty) begin
                                o_cmd.op     = OP_REPLY;
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.op = (i_kind == KIND_POP_FRONT) ?
                                           OP_POP_FRONT : OP_POP_REAR;
                                n_state  = S_POP_WAIT;
                            end
                        end
                        KIND_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.op     = OP_REPLY;
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.op = OP_DUMP_START;
                                n_state  = S_DUMP_WAIT;
                            end
                        end
                        default: begin
                            o_cmd.op = OP_REPLY;
                        end
                    endcase
                end
            end
            S_POP_WAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_POP_OUT;
                    n_state  = S_IDLE;
                end
            end
            S_DUMP_WAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_DUMP_OUT;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// Pushes and rejected operations: result is registered at the accepting edge and
// shows in the next cycle; a new item can be taken every cycle while the output is free.
// Pops: the synchronous RAM read is registered, then the result is loaded once the output is free.
// Dump of N stored values: one RAM read, then one result per cycle while the output is free.
// Synchronous active-low reset empties the queue and the output register; the
// storage RAM keeps its contents and needs no clearing pass.
`default_nettype none

module double_ended_queue
    import dq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,  // kind[2:0], value[34:3], zero pad.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [DATA_W-1:0]     m_axis_tdata,  // data[31:0].
    output logic      [STAT_W-1:0]     m_axis_tuser,  // status[1:0].
    output logic                       m_axis_tlast
);

    t_cmd     cmd;
    t_dp_stat dp_stat;
    t_status  out_status;

    dq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .i_kind (s_axis_tdata[KIND_W-1:0]),
        .o_ready(s_axis_tready),
        .i_stat (dp_stat),
        .o_cmd  (cmd)
    );

    dq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (s_axis_tdata[KIND_W +: DATA_W]),
        .o_stat      (dp_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_status(out_status),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

// ===== rtl/core/dq_checker.sv =====
`default_nettype none

module dq_checker
    import dq_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [DATA_W-1:0]     m_axis_tdata,
    input wire logic [STAT_W-1:0]     m_axis_tuser,
    input wire logic                  m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("Stalled output item changed.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_FULL) |->
            m_axis_tlast && (m_axis_tdata == '0))
        else $error("Error item is not a single zero item.");

    a_push_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tdata[KIND_W-1:0] == KIND_PUSH_FRONT ||
         s_axis_tdata[KIND_W-1:0] == KIND_PUSH_REAR) |=>
            m_axis_tvalid && m_axis_tlast && (m_axis_tdata == '0) &&
            (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL))
        else $error("Push did not answer in the next cycle.");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

`default_nettype wire
